// ===== design/teq_pkg.sv =====
// Shared types and constants for the timed event queue.
// Used by teq_store and timed_event_queue; no dependencies.
`timescale 1ns / 1ps

package teq_pkg;

	// Fixed field widths
	localparam int TIME_W      = 32;
	localparam int IN_ID_W     = 16;
	localparam int KIND_W      = 3;
	localparam int SRC_W       = 2;
	localparam int STAT_W      = 2;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 56;

	// Defaults for the top-level parameters
	localparam int DEF_CAPACITY = 32;
	localparam int DEF_ID_BITS  = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Command codes carried on the input beat
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD      = 3'd0,
		KIND_REMOVE   = 3'd1,
		KIND_ADVANCE  = 3'd2,
		KIND_DUMP_ALL = 3'd3,
		KIND_DUMP_AT  = 3'd4
	} kind_t;

	// Origin of an output beat
	typedef enum logic [SRC_W-1:0] {
		SRC_FIRED  = 2'd0,
		SRC_LISTED = 2'd1,
		SRC_STATUS = 2'd2
	} src_t;

	// Add outcome
	typedef enum logic [STAT_W-1:0] {
		ST_ACCEPTED = 2'd0,
		ST_PAST     = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

endpackage

// ===== design/timed_event_queue.sv =====
// Timed event queue top level: command sequencer, time register, output stage.
// Depends on teq_pkg and teq_store.
`timescale 1ns / 1ps
//
//  Channel  Dir  Beat contents
//  s_*      in   tuser: kind; tdata: time_value, event_id
//  m_*      out  tuser: source; tdata: status, out_time, out_id; tlast: last
//
//  Scans and accepted adds walk the store one entry at a time through a single
//  read port and one compare stage; an add that lands inside the queue then
//  moves the later entries up one place. s_tready is high only between
//  commands. A stalled output holds the walk; the final beat sits in the
//  output register while the next command is taken. Reset empties the queue
//  and zeroes the time at once; no clearing pass.

module timed_event_queue #(
	parameter int CAPACITY = teq_pkg::DEF_CAPACITY,
	parameter int ID_BITS  = teq_pkg::DEF_ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [teq_pkg::S_TDATA_W-1:0] s_tdata,  // time_value[31:0], event_id[47:32]
	input  logic [teq_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [teq_pkg::M_TDATA_W-1:0] m_tdata,  // status[1:0], out_time[33:2],
	                                                // out_id[49:34], zero pad
	output logic [teq_pkg::SRC_W-1:0]     m_tuser,  // source[1:0]
	output logic                          m_tlast
);
	import teq_pkg::*;

	localparam int IdxW = $clog2(CAPACITY);
	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int IdW  = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INSERT,
		ST_ADD_DONE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_SCAN_FIN
	} state_t;

	typedef struct packed {
		src_t                src;
		status_t             status;
		logic [TIME_W-1:0]   tm;
		logic [IN_ID_W-1:0]  id;
	} res_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [TIME_W-1:0] tv_q;
	logic [IdW-1:0]    id_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] nt_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   idx_q;
	logic [CntW-1:0]   wr_idx_q;
	logic [CntW-1:0]   keep_q;
	status_t           status_q;
	logic              pend_valid_q;
	res_t              pend_q;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_last_q;

	logic              wr_en;
	logic [IdxW-1:0]   wr_addr;
	logic [TIME_W-1:0] wr_time;
	logic [IdW-1:0]    wr_id;
	logic [IdxW-1:0]   rd_addr;
	logic [TIME_W-1:0] rd_time;
	logic [IdW-1:0]    rd_id;

	logic              in_fire;
	kind_t             in_kind;
	logic [TIME_W-1:0] in_time;
	logic [IdW-1:0]    in_id;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat_time;
	logic              out_free;
	logic              out_load;
	logic [CntW-1:0]   idx_nxt;
	logic [CntW-1:0]   shift_src;
	logic              last_entry;
	logic              t_eq;
	logic              t_gt_old;
	logic              t_le_nt;
	logic              t_le_tv;
	logic              emit;
	logic              keep;
	logic              compact;
	logic              stall;
	res_t              new_res;

	teq_store #(
		.DEPTH (CAPACITY),
		.ID_W  (IdW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_time (wr_time),
		.wr_id   (wr_id),
		.rd_addr (rd_addr),
		.rd_time (rd_time),
		.rd_id   (rd_id)
	);

	// Input decode and saturating time sum
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign in_kind  = kind_t'(s_tuser);
	assign in_time  = s_tdata[TIME_W-1:0];
	assign in_id    = s_tdata[TIME_W +: IdW];
	assign sum      = {1'b0, now_q} + {1'b0, in_time};
	assign sat_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

	// Compare stage on the entry just read
	assign t_eq      = (rd_time == tv_q);
	assign t_gt_old  = (rd_time > now_q);
	assign t_le_nt   = (rd_time <= nt_q);
	assign t_le_tv   = (rd_time <= tv_q);
	assign idx_nxt   = idx_q + CntW'(1);
	assign shift_src = wr_idx_q - CntW'(1);
	assign last_entry = (idx_nxt == count_q);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		emit    = 1'b0;
		keep    = 1'b0;
		compact = 1'b0;
		case (kind_q)
			KIND_REMOVE: begin
				keep    = !t_eq;
				compact = 1'b1;
			end
			KIND_ADVANCE: begin
				emit    = t_gt_old && t_le_nt;
				keep    = !t_le_nt;
				compact = 1'b1;
			end
			KIND_DUMP_ALL: emit = 1'b1;
			KIND_DUMP_AT:  emit = t_eq;
			default: ;
		endcase
	end

	assign stall = emit && pend_valid_q && !out_free;

	// A beat moves into the output register
	assign out_load = ((state_q == ST_ADD_DONE) && out_free) ||
		((state_q == ST_SCAN_EV) && emit && pend_valid_q && !stall) ||
		((state_q == ST_SCAN_FIN) && pend_valid_q && out_free);

	always_comb begin
		new_res.src    = (kind_q == KIND_ADVANCE) ? SRC_FIRED : SRC_LISTED;
		new_res.status = ST_ACCEPTED;
		new_res.tm     = rd_time;
		new_res.id     = IN_ID_W'(rd_id);
	end

	// Store port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = keep_q[IdxW-1:0];
		wr_time = rd_time;
		wr_id   = rd_id;
		rd_addr = idx_q[IdxW-1:0];
		unique case (state_q)
			ST_SHIFT_RD: rd_addr = shift_src[IdxW-1:0];
			ST_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = wr_idx_q[IdxW-1:0];
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[IdxW-1:0];
				wr_time = tv_q;
				wr_id   = id_q;
			end
			ST_SCAN_EV: wr_en = compact && keep && !stall;
			default: ;
		endcase
	end

	// Sequencer, time register and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_ADD;
			tv_q         <= '0;
			id_q         <= '0;
			now_q        <= '0;
			nt_q         <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			wr_idx_q     <= '0;
			keep_q       <= '0;
			status_q     <= ST_ACCEPTED;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						kind_q <= in_kind;
						tv_q   <= in_time;
						id_q   <= in_id;
						nt_q   <= sat_time;
						idx_q  <= '0;
						keep_q <= '0;
						case (in_kind) inside
							KIND_ADD: begin
								if (in_time < now_q) begin
									status_q <= ST_PAST;
									state_q  <= ST_ADD_DONE;
								end else if (count_q == CntW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= ST_ADD_DONE;
								end else begin
									status_q <= ST_ACCEPTED;
									state_q  <= (count_q == '0) ? ST_INSERT : ST_FIND_RD;
								end
							end
							KIND_REMOVE, KIND_ADVANCE, KIND_DUMP_ALL, KIND_DUMP_AT: begin
								state_q <= (count_q == '0) ? ST_SCAN_FIN : ST_SCAN_RD;
							end
							default: ;
						endcase
					end
				end
				ST_FIND_RD: state_q <= ST_FIND_EV;
				ST_FIND_EV: begin
					// Ties go after existing entries of the same time
					if (t_le_tv) begin
						idx_q <= idx_nxt;
						state_q <= last_entry ? ST_INSERT : ST_FIND_RD;
					end else begin
						wr_idx_q <= count_q;
						state_q  <= ST_SHIFT_RD;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= (wr_idx_q == idx_q) ? ST_INSERT : ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					wr_idx_q <= shift_src;
					state_q  <= ST_SHIFT_RD;
				end
				ST_INSERT: begin
					count_q <= count_q + CntW'(1);
					state_q <= ST_ADD_DONE;
				end
				ST_ADD_DONE: begin
					if (out_free) begin
						out_last_q    <= 1'b1;
						out_q.src     <= SRC_STATUS;
						out_q.status  <= status_q;
						out_q.tm      <= tv_q;
						out_q.id      <= IN_ID_W'(id_q);
						state_q       <= ST_IDLE;
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_EV;
				ST_SCAN_EV: begin
					if (!stall) begin
						// One-beat lookahead so the final beat can carry tlast
						if (emit) begin
							if (pend_valid_q) begin
								out_last_q  <= 1'b0;
								out_q       <= pend_q;
							end
							pend_valid_q <= 1'b1;
							pend_q       <= new_res;
						end
						if (compact && keep) begin
							keep_q <= keep_q + CntW'(1);
						end
						idx_q   <= idx_nxt;
						state_q <= last_entry ? ST_SCAN_FIN : ST_SCAN_RD;
					end
				end
				ST_SCAN_FIN: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_last_q   <= 1'b1;
							out_q        <= pend_q;
							pend_valid_q <= 1'b0;
						end
						if (compact) begin
							count_q <= keep_q;
						end
						if (kind_q == KIND_ADVANCE) begin
							now_q <= nt_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output beat
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.src;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_TDATA_W - STAT_W - TIME_W - IN_ID_W){1'b0}},
		out_q.id, out_q.tm, out_q.status};

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_pend_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("held result left over at command end");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> now_q >= $past(now_q))
		else $error("current time went backwards");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CntW'(wr_addr) <= count_q)
		else $error("store write beyond occupied range");

endmodule

// ===== design/teq_store.sv =====
// Sorted event store: one write port, one read port with registered data.
// Depends on teq_pkg.
`timescale 1ns / 1ps

module teq_store #(
	parameter int DEPTH = teq_pkg::DEF_CAPACITY,
	parameter int ID_W  = teq_pkg::DEF_ID_BITS
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [teq_pkg::TIME_W-1:0]  wr_time,
	input  logic [ID_W-1:0]             wr_id,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [teq_pkg::TIME_W-1:0]  rd_time,
	output logic [ID_W-1:0]             rd_id
);
	import teq_pkg::*;

	logic [TIME_W-1:0] time_mem [DEPTH];
	logic [ID_W-1:0]   id_mem   [DEPTH];
	logic [TIME_W-1:0] rd_time_q;
	logic [ID_W-1:0]   rd_id_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= wr_time;
			id_mem[wr_addr]   <= wr_id;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_time_q <= time_mem[rd_addr];
		rd_id_q   <= id_mem[rd_addr];
	end

	assign rd_time = rd_time_q;
	assign rd_id   = rd_id_q;

endmodule
